// ===== rtl/jof_pkg.sv =====
// Package of shared types and constants for the JSON object framer.
`timescale 1ns / 1ps

package jof_pkg;

   // Register and counter widths
   localparam int CFG_BITS = 24;
   localparam int LEN_BITS = 25;

   // Frame length limit after reset: 1024 * 1024 bytes
   localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(1024 * 1024);

   // Bytes that steer the framer
   localparam logic [7:0] OPEN_BRACE  = 8'h7B;
   localparam logic [7:0] CLOSE_BRACE = 8'h7D;
   localparam logic [7:0] QUOTE       = 8'h22;
   localparam logic [7:0] BACKSLASH   = 8'h5C;

   // Bit positions of the flags in rsp_tuser
   localparam int USER_BITS      = 3;
   localparam int USER_BYTE_VLD  = 0;
   localparam int USER_START     = 1;
   localparam int USER_ABORT     = 2;

   // One result transaction
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       frame_start;
      logic       frame_end;
      logic       frame_abort;
   } result_type;

endpackage

// ===== rtl/json_object_framer.sv =====
// JSON object framer: passes on the bytes of top-level objects and marks frame edges.
`timescale 1ns / 1ps
//
// Usage
//   req_*  : raw stream bytes, one byte per transaction in req_tdata.
//   rsp_*  : frame bytes and abort notices. rsp_tdata holds the byte (zero when
//            the transaction only reports an abort), rsp_tuser holds byte_valid,
//            frame_start and frame_abort, rsp_tlast marks the closing brace of
//            a top-level object.
//   csr_*  : csr_wr_en writes csr_wr_data into the frame length limit; write
//            only while the stream is idle.
// Throughput
//   One byte is accepted every cycle while req_tready is high. Its result, if any, is
//   registered in the output register, or in the skid slot while the output register
//   is full. Per-byte state update (depth, string, escape, length) is combinational.
// Reset
//   Synchronous, active high. Clears depth, string and escape flags, the
//   frame length, both output slots, and loads the limit with 1048576.
// Stall
//   An output register plus a skid slot absorb one extra result, so req_tready
//   stays high while one result waits; it drops only when both slots are full,
//   and then every byte waits, including bytes that would cause no result.

module json_object_framer #(
   parameter int DEPTH_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // input stream
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] in_byte
   // result stream
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [7:0] out_byte
   output logic [jof_pkg::USER_BITS-1:0] rsp_tuser, // [0] byte_valid, [1] frame_start,
                                                    // [2] frame_abort
   output logic                        rsp_tlast,   // frame_end
   // configuration
   input  logic                        csr_wr_en,
   input  logic [jof_pkg::CFG_BITS-1:0] csr_wr_data
);

   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = {DEPTH_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);

   // State registers
   logic [jof_pkg::CFG_BITS-1:0] max_len_ff;
   logic [DEPTH_BITS-1:0]        depth_ff, depth_in;
   logic                         in_str_ff, in_str_in;
   logic                         esc_ff, esc_in;
   logic [jof_pkg::LEN_BITS-1:0] len_ff, len_in;

   // Output slots
   jof_pkg::result_type          out_ff, skid_ff, res;
   logic                         out_vld_ff, skid_vld_ff;
   logic                         res_emit;

   logic                         req_take, rsp_take;

   assign req_tready = !skid_vld_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = out_vld_ff && rsp_tready;

   // Per-byte state update
   always_comb begin
      logic [DEPTH_BITS-1:0] d;
      logic                  s;
      logic                  e;
      logic [jof_pkg::LEN_BITS-1:0] l;
      logic                  vld;
      logic                  start;
      logic                  fend;
      logic                  abort;

      d     = depth_ff;
      s     = in_str_ff;
      e     = esc_ff;
      l     = len_ff;
      vld   = 1'b0;
      start = 1'b0;
      fend  = 1'b0;
      abort = 1'b0;

      // length limit check comes before the byte is looked at
      if (len_ff > {1'b0, max_len_ff}) begin
         d     = '0;
         s     = 1'b0;
         e     = 1'b0;
         l     = '0;
         abort = 1'b1;
      end

      if (s) begin
         vld = 1'b1;
         if (req_tdata == jof_pkg::QUOTE && !e) begin
            s = 1'b0;
         end
         e = !e && (req_tdata == jof_pkg::BACKSLASH);
      end else if (req_tdata == jof_pkg::QUOTE && d != '0) begin
         vld = 1'b1;
         s   = 1'b1;
         e   = 1'b0;
      end else if (req_tdata == jof_pkg::OPEN_BRACE) begin
         if (d == DEPTH_FULL) begin
            // depth overflow drops the byte and the open frame
            d     = '0;
            s     = 1'b0;
            e     = 1'b0;
            l     = '0;
            abort = 1'b1;
         end else begin
            start = (d == '0);
            d     = d + DEPTH_ONE;
            vld   = 1'b1;
         end
      end else if (req_tdata == jof_pkg::CLOSE_BRACE) begin
         if (d != '0) begin
            vld  = 1'b1;
            fend = (d == DEPTH_ONE);
            d    = d - DEPTH_ONE;
         end
      end else if (d != '0) begin
         vld = 1'b1;
      end

      if (vld) begin
         l = l + jof_pkg::LEN_BITS'(1);
      end
      if (fend) begin
         l = '0;
      end

      depth_in  = d;
      in_str_in = s;
      esc_in    = e;
      len_in    = l;

      res.out_byte    = vld ? req_tdata : 8'h00;
      res.byte_valid  = vld;
      res.frame_start = start;
      res.frame_end   = fend;
      res.frame_abort = abort;
      res_emit        = vld || abort;
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= jof_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // Framer state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         in_str_ff <= 1'b0;
         esc_ff    <= 1'b0;
         len_ff    <= '0;
      end else if (req_take) begin
         depth_ff  <= depth_in;
         in_str_ff <= in_str_ff ^ (in_str_in ^ in_str_ff);
         esc_ff    <= esc_in;
         len_ff    <= len_in;
      end
   end

   // Output register and skid slot control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (rsp_take) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= req_take && res_emit;
         end
      end else if (req_take && res_emit) begin
         if (out_vld_ff) begin
            skid_vld_ff <= 1'b1;
         end else begin
            out_vld_ff <= 1'b1;
         end
      end
   end

   // Output payloads
   always_ff @(posedge clock) begin
      if (rsp_take) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (req_take) begin
            out_ff <= res;
         end
      end else if (req_take && res_emit) begin
         if (out_vld_ff) begin
            skid_ff <= res;
         end else begin
            out_ff <= res;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff.out_byte;
   assign rsp_tlast  = out_ff.frame_end;
   assign rsp_tuser[jof_pkg::USER_BYTE_VLD] = out_ff.byte_valid;
   assign rsp_tuser[jof_pkg::USER_START]    = out_ff.frame_start;
   assign rsp_tuser[jof_pkg::USER_ABORT]    = out_ff.frame_abort;

endmodule

// ===== rtl/jof_checker.sv =====
// Port-level checks for the JSON object framer, bound to the top level.
`timescale 1ns / 1ps

module jof_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [7:0]                    rsp_tdata,
   input logic [jof_pkg::USER_BITS-1:0] rsp_tuser,
   input logic                          rsp_tlast
);

   // A waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Input back-pressure only while a result is on offer
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   // Frame start is always the opening brace carried as a frame byte
   a_start_brace: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[jof_pkg::USER_START] |->
         rsp_tuser[jof_pkg::USER_BYTE_VLD] && rsp_tdata == jof_pkg::OPEN_BRACE)
      else $error("frame start not on an opening brace");

   // Frame end is always the closing brace carried as a frame byte
   a_end_brace: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tuser[jof_pkg::USER_BYTE_VLD] && rsp_tdata == jof_pkg::CLOSE_BRACE)
      else $error("frame end not on a closing brace");

   // A transaction without a byte is a bare abort notice with zero data
   a_abort_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[jof_pkg::USER_BYTE_VLD] |->
         rsp_tuser[jof_pkg::USER_ABORT] && rsp_tdata == 8'h00 &&
         !rsp_tuser[jof_pkg::USER_START] && !rsp_tlast)
      else $error("empty result without abort");

endmodule

bind json_object_framer jof_checker u_jof_checker (.*);

// ===== tb/json_object_framer_checker.sv =====
// Checker for the JSON object framer: predicts each result and compares the result stream.
`timescale 1ns / 1ps

module json_object_framer_checker #(
   parameter int DEPTH_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] in_byte
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   input  logic [jof_pkg::USER_BITS-1:0] rsp_tuser,   // [0] byte_valid, [1] frame_start,
                                                      // [2] frame_abort
   input  logic                          rsp_tlast,   // frame_end
   input  logic                          csr_wr_en,
   input  logic [jof_pkg::CFG_BITS-1:0]  csr_wr_data,
   output int                            pending,
   output int                            fail_count
);

   // Shadow framer state
   logic [jof_pkg::CFG_BITS-1:0] frame_limit;
   logic [DEPTH_BITS-1:0]        nest_level;
   logic                         in_quotes;
   logic                         escape_armed;
   logic [jof_pkg::LEN_BITS-1:0] held_bytes;

   jof_pkg::result_type awaited_q[$];
   int                  fail_total;

   task automatic drop_frame();
      nest_level   = '0;
      in_quotes    = 1'b0;
      escape_armed = 1'b0;
      held_bytes   = '0;
   endtask

   // One stream byte through the framer; queues the result it causes, if any
   task automatic advance_framer(input logic [7:0] b);
      jof_pkg::result_type res;
      res = '0;
      // over-long open frame is discarded before the byte is looked at
      if (held_bytes > {1'b0, frame_limit}) begin
         drop_frame();
         res.frame_abort = 1'b1;
      end
      if (in_quotes) begin
         res.byte_valid = 1'b1;
         if (b == jof_pkg::QUOTE && !escape_armed)
            in_quotes = 1'b0;
         escape_armed = !escape_armed && (b == jof_pkg::BACKSLASH);
      end else if (b == jof_pkg::QUOTE && nest_level != 0) begin
         res.byte_valid = 1'b1;
         in_quotes      = 1'b1;
         escape_armed   = 1'b0;
      end else if (b == jof_pkg::OPEN_BRACE) begin
         if (nest_level == '1) begin
            // depth counter would wrap: abort and drop the brace
            drop_frame();
            res.frame_abort = 1'b1;
         end else begin
            if (nest_level == 0)
               res.frame_start = 1'b1;
            nest_level     = nest_level + DEPTH_BITS'(1);
            res.byte_valid = 1'b1;
         end
      end else if (b == jof_pkg::CLOSE_BRACE) begin
         if (nest_level != 0) begin
            res.byte_valid = 1'b1;
            nest_level     = nest_level - DEPTH_BITS'(1);
            if (nest_level == 0)
               res.frame_end = 1'b1;
         end
      end else if (nest_level != 0) begin
         res.byte_valid = 1'b1;
      end

      if (res.byte_valid)
         held_bytes = held_bytes + jof_pkg::LEN_BITS'(1);
      if (res.frame_end)
         held_bytes = '0;

      if (res.byte_valid || res.frame_abort) begin
         res.out_byte = res.byte_valid ? b : 8'h00;
         awaited_q.push_back(res);
      end
   endtask

   always @(posedge clock) begin : watch
      jof_pkg::result_type want;
      jof_pkg::result_type got;
      if (reset) begin
         awaited_q.delete();
         frame_limit = jof_pkg::CFG_RESET;
         drop_frame();
         fail_total = 0;
      end else begin
         // result side first: a result never belongs to a byte taken at this edge
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte    = rsp_tdata;
            got.byte_valid  = rsp_tuser[jof_pkg::USER_BYTE_VLD];
            got.frame_start = rsp_tuser[jof_pkg::USER_START];
            got.frame_end   = rsp_tlast;
            got.frame_abort = rsp_tuser[jof_pkg::USER_ABORT];
            if (awaited_q.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: unexpected result byte %02h valid %b start %b end %b abort %b",
                           $realtime, got.out_byte, got.byte_valid, got.frame_start,
                           got.frame_end, got.frame_abort);
            end else begin
               want = awaited_q.pop_front();
               if (got !== want) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display({"%0t: mismatch: expected byte %02h valid %b start %b end %b",
                               " abort %b, got byte %02h valid %b start %b end %b abort %b"},
                              $realtime, want.out_byte, want.byte_valid, want.frame_start,
                              want.frame_end, want.frame_abort, got.out_byte, got.byte_valid,
                              got.frame_start, got.frame_end, got.frame_abort);
               end
            end
         end
         if (csr_wr_en)
            frame_limit = csr_wr_data;
         if (req_tvalid && req_tready)
            advance_framer(req_tdata);
      end
      pending    <= awaited_q.size();
      fail_count <= fail_total;
   end

endmodule

// ===== tb/tb_json_object_framer.sv =====
// Testbench top for the JSON object framer: stream stimulus, idling, pressure and verdict.
`timescale 1ns / 1ps

module tb_json_object_framer;

   localparam int DEPTH_BITS      = 8;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int CFG_W           = jof_pkg::CFG_BITS;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_tvalid  = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata   = 8'h00;
   logic                          rsp_tvalid;
   logic                          rsp_tready  = 1'b0;
   logic [7:0]                    rsp_tdata;
   logic [jof_pkg::USER_BITS-1:0] rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]              csr_wr_data = '0;

   int pending;
   int fail_count;

   // Stimulus control shared with the receiver
   logic req_steady    = 1'b0;
   logic rsp_steady    = 1'b0;
   int   hold_requests = 0;

   logic [7:0] stream_bytes[$];
   int         bytes_sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   json_object_framer #(.DEPTH_BITS(DEPTH_BITS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   json_object_framer_checker #(.DEPTH_BITS(DEPTH_BITS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   // Byte inside an object but outside a string that does not steer the framer
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == jof_pkg::QUOTE || b == jof_pkg::OPEN_BRACE || b == jof_pkg::CLOSE_BRACE);
      return b;
   endfunction

   // Unescaped string content
   function automatic logic [7:0] string_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == jof_pkg::QUOTE || b == jof_pkg::BACKSLASH);
      return b;
   endfunction

   // Well-formed object with random content, nesting up to six levels
   function automatic void build_object(input int budget);
      int lvl;
      int n;
      int k;
      stream_bytes.push_back(jof_pkg::OPEN_BRACE);
      lvl = 1;
      n   = 1;
      while (lvl > 0) begin
         if (n >= budget) begin
            stream_bytes.push_back(jof_pkg::CLOSE_BRACE);
            lvl--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  if (lvl < 6) begin
                     stream_bytes.push_back(jof_pkg::OPEN_BRACE);
                     lvl++;
                  end else begin
                     stream_bytes.push_back(plain_byte());
                  end
               end
               2, 3: begin
                  stream_bytes.push_back(jof_pkg::CLOSE_BRACE);
                  lvl--;
               end
               4, 5: begin
                  stream_bytes.push_back(jof_pkg::QUOTE);
                  k = $urandom_range(0, 6);
                  repeat (k) begin
                     if ($urandom_range(0, 3) == 0) begin
                        stream_bytes.push_back(jof_pkg::BACKSLASH);
                        stream_bytes.push_back(8'($urandom_range(0, 255)));
                     end else begin
                        stream_bytes.push_back(string_byte());
                     end
                  end
                  stream_bytes.push_back(jof_pkg::QUOTE);
               end
               default: stream_bytes.push_back(plain_byte());
            endcase
         end
         n++;
      end
   endfunction

   // Offer every queued byte, one transaction each, with random gaps unless req_steady is set
   task automatic send_stream();
      int gap;
      while (stream_bytes.size() > 0) begin
         gap = req_steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stream_bytes.pop_front();
         do
            @(posedge clock);
         while (!req_tready);
         bytes_sent++;
      end
   endtask

   // Stop offering and wait for every awaited result, then for trailing no-result bytes
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic under one limit; lenient phases may leave frames open,
   // which a short limit clears again
   task automatic run_phase(input logic [CFG_W-1:0] limit, input int nbytes,
                            input bit lenient);
      int         stop_at;
      int         k;
      logic [7:0] b;
      write_limit(limit);
      req_steady = ($urandom_range(0, 3) == 0);
      rsp_steady = ($urandom_range(0, 3) == 0);
      stop_at    = bytes_sent + nbytes;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: begin
               // noise between objects
               k = $urandom_range(1, 4);
               repeat (k) begin
                  b = 8'($urandom_range(0, 255));
                  if (!lenient && b == jof_pkg::OPEN_BRACE)
                     b = jof_pkg::CLOSE_BRACE;
                  stream_bytes.push_back(b);
               end
            end
            1: begin
               if (lenient) begin
                  // truncated object
                  stream_bytes.push_back(jof_pkg::OPEN_BRACE);
                  k = $urandom_range(1, 8);
                  repeat (k) stream_bytes.push_back(8'($urandom_range(0, 255)));
               end else begin
                  k = $urandom_range(1, 2);
                  repeat (k) stream_bytes.push_back(jof_pkg::CLOSE_BRACE);
               end
            end
            default: begin
               if ($urandom_range(0, 7) == 0)
                  build_object($urandom_range(20, 80));
               else
                  build_object($urandom_range(1, 20));
            end
         endcase
         send_stream();
      end
   endtask

   // Receiver: random stalls per transaction, plus one long hold-off on request
   initial begin : rsp_side
      int gap;
      int holds_served;
      holds_served = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_requests > holds_served) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            holds_served++;
         end else begin
            gap = rsp_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            do
               @(posedge clock);
            while (!rsp_tvalid);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long
   initial begin : stall_watch
      int stall_cycles;
      stall_cycles = 0;
      wait (reset == 1'b0);
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: byte extremes outside a frame, stray close, bare quote, braces and
      // escapes inside a string, nesting, and an empty object
      stream_bytes = '{8'h00, 8'hFF, jof_pkg::CLOSE_BRACE, jof_pkg::QUOTE, 8'h61,
                       jof_pkg::OPEN_BRACE, jof_pkg::QUOTE, jof_pkg::OPEN_BRACE,
                       jof_pkg::CLOSE_BRACE, jof_pkg::BACKSLASH, jof_pkg::QUOTE,
                       jof_pkg::BACKSLASH, jof_pkg::BACKSLASH, jof_pkg::QUOTE,
                       jof_pkg::OPEN_BRACE, 8'h00, 8'hFF, jof_pkg::CLOSE_BRACE,
                       jof_pkg::CLOSE_BRACE, jof_pkg::CLOSE_BRACE, jof_pkg::OPEN_BRACE,
                       jof_pkg::CLOSE_BRACE};
      send_stream();

      // Depth overflow: fill the depth counter, then one more open brace
      req_steady = 1'b1;
      repeat ((1 << DEPTH_BITS) - 1) stream_bytes.push_back(jof_pkg::OPEN_BRACE);
      stream_bytes.push_back(jof_pkg::OPEN_BRACE);
      send_stream();

      run_phase(24'hFFFFFF, 100, 1'b0);

      // Long receiver hold-off while a long object keeps coming, then drain
      hold_requests++;
      req_steady = 1'b1;
      stream_bytes.push_back(jof_pkg::OPEN_BRACE);
      stream_bytes.push_back(jof_pkg::QUOTE);
      repeat (60) stream_bytes.push_back(string_byte());
      stream_bytes.push_back(jof_pkg::QUOTE);
      stream_bytes.push_back(jof_pkg::CLOSE_BRACE);
      send_stream();
      wait_drained();

      // Short limits, zero among them, abort frames and resynchronize
      run_phase('0, 120, 1'b1);
      run_phase(24'd1, 100, 1'b1);
      run_phase(24'd6, 120, 1'b1);
      run_phase(CFG_W'($urandom_range(2, 64)), 120, 1'b1);
      run_phase(CFG_W'($urandom_range(2, 64)), 120, 1'b1);
      run_phase(jof_pkg::CFG_RESET, 120, 1'b0);
      run_phase(CFG_W'($urandom_range(100, 4000)), 120, 1'b0);

      wait_drained();
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/jof_pkg.sv
rtl/json_object_framer.sv
rtl/jof_checker.sv
tb/json_object_framer_checker.sv
tb/tb_json_object_framer.sv
